// ===== rtl/dmtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dmtq_pkg: shared types and constants of the delayed message time queue
// Entry layout, channel words and mode codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmtq_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned DELAY_W   = 24;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W     = ((TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W) + 1;

  typedef enum logic [2:0] {
    MODE_DELAYED  = 3'd0,
    MODE_FRONT    = 3'd1,
    MODE_RM_CODE  = 3'd2,
    MODE_RM_CB    = 3'd3,
    MODE_QUERY    = 3'd4,
    MODE_TICK     = 3'd5,
    MODE_STOP     = 3'd6,
    MODE_NONE     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_STOPPED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic signed [31:0]   code;
    logic [7:0]           cb;
  } entry_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] msg_code;
    logic [7:0]         callback_id;
    logic [DELAY_W-1:0] delay_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [CNT_W-1:0]   pending_count;
    logic               dispatch_valid;
    logic signed [31:0] out_code;
    logic [7:0]         out_callback;
    logic               last;
  } out_word_t;

endpackage

// ===== rtl/dmtq_if.sv =====
// ----------------------------------------------------------------------------
// dmtq_in_if / dmtq_out_if: valid/ready channels of the queue
// One word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dmtq_in_if;
  import dmtq_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dmtq_out_if;
  import dmtq_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dmtq_store.sv =====
// ----------------------------------------------------------------------------
// dmtq_store: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmtq_store #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/delayed_message_time_queue.sv =====
// ----------------------------------------------------------------------------
// delayed_message_time_queue: sorted timer event queue
// Up to DEPTH messages kept in due-time order, advanced by tick words.
//
// Channels: in_i takes one command word (mode, msg_code, callback_id,
// delay_ms); out_o returns result words, each marked last on the final one.
// A tick returns one word per released message, or a single word if none.
// Every word carries the count left after the whole command.
// A sequencer walks the entries one per cycle, holding while a tick's
// release word waits for the receiver; the entry RAM reads one step ahead
// of the walk. in_i.ready is high only while the sequencer is idle, so a
// new command is taken only once the sequencer has finished the last one.
// The result word sits in an output register; while the receiver stalls,
// the sequencer holds before producing the next word.
// Reset empties the queue, clears the clock to zero and sets it running.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delayed_message_time_queue
  import dmtq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dmtq_in_if.sink   in_i,
  dmtq_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_INS, S_WALK, S_TCNT, S_TEMIT, S_TSHIFT, S_RESP
  } state_e;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  state_e               state_q;
  logic [2:0]           mode_q;
  logic signed [31:0]   code_q;
  logic [7:0]           cb_q;
  logic [TIME_BITS-1:0] due_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 running_q;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     ptr_q;
  logic [CNT_W-1:0]     wptr_q;
  logic [CNT_W-1:0]     ndue_q;
  logic [1:0]           status_q;
  logic                 found_q;
  logic                 ovalid_q;
  out_word_t            oword_q;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               rdata;
  logic                 slot_free;
  logic                 oword_load;
  logic                 is_ins;
  logic                 ins_stop;
  logic                 tcnt_more;
  logic [SUM_W-1:0]     due_sum;
  logic [TIME_BITS-1:0] due_sat;
  logic [TIME_BITS:0]   now_sum;
  logic [TIME_BITS-1:0] now_inc;
  logic                 walk_hit;
  logic [CNT_W-1:0]     ptr_m1;
  logic [CNT_W-1:0]     ptr_m2;
  logic [CNT_W-1:0]     ptr_p1;
  logic [CNT_W-1:0]     cnt_m1;

  dmtq_store #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign slot_free = !ovalid_q || out_o.ready;
  assign oword_load = slot_free && (state_q == S_TEMIT || state_q == S_RESP);
  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = ovalid_q;
  assign out_o.data  = oword_q;

  assign is_ins  = (in_i.data.mode == MODE_DELAYED) || (in_i.data.mode == MODE_FRONT);
  assign due_sum = SUM_W'(now_q) + SUM_W'(in_i.data.delay_ms);
  assign due_sat = (due_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : due_sum[TIME_BITS-1:0];
  assign now_sum = {1'b0, now_q} + {{TIME_BITS{1'b0}}, 1'b1};
  assign now_inc = now_sum[TIME_BITS] ? TIME_MAX : now_sum[TIME_BITS-1:0];
  assign ptr_m1  = ptr_q - CNT_W'(1);
  assign ptr_m2  = ptr_q - CNT_W'(2);
  assign ptr_p1  = ptr_q + CNT_W'(1);
  assign cnt_m1  = count_q - CNT_W'(1);

  assign ins_stop  = (ptr_q == '0) || (mode_q == MODE_DELAYED && rdata.due <= due_q);
  assign tcnt_more = (ptr_q < count_q) && (rdata.due <= now_q);
  assign walk_hit  = (mode_q == MODE_RM_CB) ? (rdata.cb == cb_q) : (rdata.code == code_q);

  // read address runs one entry ahead of the walk
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[IDX_W-1:0];
    ram_wdata = '{due: due_q, code: code_q, cb: cb_q};
    ram_raddr = ptr_p1[IDX_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_raddr = is_ins ? cnt_m1[IDX_W-1:0] : '0;
      end
      S_INS: begin
        ram_raddr = ptr_m2[IDX_W-1:0];
        ram_we    = 1'b1;
        if (!ins_stop) begin
          ram_wdata = rdata;
        end
      end
      S_WALK: begin
        ram_waddr = wptr_q[IDX_W-1:0];
        ram_wdata = rdata;
        ram_we    = (ptr_q < count_q) && !walk_hit && (mode_q != MODE_QUERY);
      end
      S_TCNT: begin
        ram_raddr = tcnt_more ? ptr_p1[IDX_W-1:0] : '0;
      end
      S_TEMIT: begin
        ram_raddr = slot_free ? ptr_p1[IDX_W-1:0] : ptr_q[IDX_W-1:0];
      end
      S_TSHIFT: begin
        ram_waddr = wptr_q[IDX_W-1:0];
        ram_wdata = rdata;
        ram_we    = (ptr_q < count_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      now_q     <= '0;
      running_q <= 1'b1;
      count_q   <= '0;
      ovalid_q  <= 1'b0;
      oword_q   <= '0;
      mode_q    <= '0;
      code_q    <= '0;
      cb_q      <= '0;
      due_q     <= '0;
      ptr_q     <= '0;
      wptr_q    <= '0;
      ndue_q    <= '0;
      status_q  <= ST_OK;
      found_q   <= 1'b0;
    end else begin
      ovalid_q <= oword_load || (ovalid_q && !out_o.ready);
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            mode_q   <= in_i.data.mode;
            code_q   <= in_i.data.msg_code;
            cb_q     <= in_i.data.callback_id;
            found_q  <= 1'b0;
            wptr_q   <= '0;
            due_q    <= (in_i.data.mode == MODE_DELAYED) ? due_sat : now_q;
            ptr_q    <= is_ins ? count_q : '0;
            unique case (mode_e'(in_i.data.mode))
              MODE_DELAYED, MODE_FRONT: begin
                if (in_i.data.mode == MODE_DELAYED && !running_q) begin
                  status_q <= ST_STOPPED;
                  state_q  <= S_RESP;
                end else if (count_q >= CNT_W'(DEPTH)) begin
                  status_q <= ST_FULL;
                  state_q  <= S_RESP;
                end else begin
                  status_q <= ST_OK;
                  state_q  <= S_INS;
                end
              end
              MODE_RM_CODE, MODE_RM_CB, MODE_QUERY: begin
                status_q <= ST_OK;
                state_q  <= S_WALK;
              end
              MODE_TICK: begin
                status_q <= ST_OK;
                now_q    <= now_inc;
                state_q  <= (running_q && count_q != '0) ? S_TCNT : S_RESP;
              end
              MODE_STOP: begin
                status_q  <= ST_OK;
                running_q <= 1'b0;
                state_q   <= S_RESP;
              end
              default: begin
                status_q <= ST_OK;
                state_q  <= S_RESP;
              end
            endcase
          end
        end
        S_INS: begin
          if (ins_stop) begin
            count_q <= count_q + CNT_W'(1);
            state_q <= S_RESP;
          end else begin
            ptr_q <= ptr_m1;
          end
        end
        S_WALK: begin
          if (ptr_q < count_q) begin
            ptr_q <= ptr_p1;
            if (walk_hit) begin
              if (mode_q == MODE_QUERY) found_q <= 1'b1;
            end else begin
              wptr_q <= wptr_q + CNT_W'(1);
            end
          end else begin
            if (mode_q != MODE_QUERY) count_q <= wptr_q;
            state_q <= S_RESP;
          end
        end
        S_TCNT: begin
          if (tcnt_more) begin
            ptr_q <= ptr_p1;
          end else begin
            ndue_q <= ptr_q;
            wptr_q <= '0;
            ptr_q  <= '0;
            state_q <= (ptr_q == '0) ? S_RESP : S_TEMIT;
          end
        end
        S_TEMIT: begin
          if (slot_free) begin
            oword_q  <= '{status: ST_OK, found: 1'b0,
                          pending_count: count_q - ndue_q, dispatch_valid: 1'b1,
                          out_code: rdata.code, out_callback: rdata.cb,
                          last: (ptr_q == ndue_q - CNT_W'(1))};
            ptr_q <= ptr_p1;
            if (ptr_q == ndue_q - CNT_W'(1)) state_q <= S_TSHIFT;
          end
        end
        S_TSHIFT: begin
          if (ptr_q < count_q) begin
            ptr_q  <= ptr_p1;
            wptr_q <= wptr_q + CNT_W'(1);
          end else begin
            count_q <= count_q - ndue_q;
            state_q <= S_IDLE;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            oword_q  <= '{status: status_q, found: found_q, pending_count: count_q,
                          dispatch_valid: 1'b0, out_code: '0, out_callback: '0,
                          last: 1'b1};
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== test/tb_delayed_message_time_queue.sv =====
// ----------------------------------------------------------------------------
// tb_delayed_message_time_queue: self-checking bench of the timer event queue
// Drives command words (inserts, removals, queries, ticks, stop) with random
// gaps and output stalls. A scoreboard keeps its own sorted queue and clock
// and checks every result word field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_delayed_message_time_queue;
  import dmtq_pkg::*;

  class msg_queue_scoreboard;
    logic [TIME_BITS-1:0] due_q[DEPTH];
    logic signed [31:0]   code_q[DEPTH];
    logic [7:0]           cb_q[DEPTH];
    int unsigned          cnt;
    logic [TIME_BITS-1:0] now_t;
    bit                   running;
    out_word_t            expected_words[$];
    int                   errors;

    function new();
      cnt = 0;
      now_t = '0;
      running = 1'b1;
      errors = 0;
    endfunction

    function logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[TIME_BITS]) return '1;
      return s[TIME_BITS-1:0];
    endfunction

    function void file_at(int unsigned pos, logic [TIME_BITS-1:0] due,
                          logic signed [31:0] code, logic [7:0] cb);
      for (int unsigned i = cnt; i > pos; i--) begin
        due_q[i] = due_q[i-1];
        code_q[i] = code_q[i-1];
        cb_q[i] = cb_q[i-1];
      end
      due_q[pos] = due;
      code_q[pos] = code;
      cb_q[pos] = cb;
      cnt++;
    endfunction

    function void drop_at(int unsigned pos);
      for (int unsigned i = pos; i + 1 < cnt; i++) begin
        due_q[i] = due_q[i+1];
        code_q[i] = code_q[i+1];
        cb_q[i] = cb_q[i+1];
      end
      cnt--;
    endfunction

    function void note_word(in_word_t w);
      out_word_t            r;
      out_word_t            released[$];
      logic [TIME_BITS-1:0] due;
      int unsigned          pos;
      int unsigned          i;
      status_e              st;
      bit                   hit;
      st = ST_OK;
      hit = 1'b0;
      case (mode_e'(w.mode))
        MODE_DELAYED: begin
          if (!running) st = ST_STOPPED;
          else if (cnt >= DEPTH) st = ST_FULL;
          else begin
            due = sat_add(now_t, TIME_BITS'(w.delay_ms));
            pos = 0;
            while (pos < cnt && due_q[pos] <= due) pos++;
            file_at(pos, due, w.msg_code, w.callback_id);
          end
        end
        MODE_FRONT: begin
          if (cnt >= DEPTH) st = ST_FULL;
          else file_at(0, now_t, w.msg_code, w.callback_id);
        end
        MODE_RM_CODE: begin
          i = 0;
          while (i < cnt) if (code_q[i] == w.msg_code) drop_at(i); else i++;
        end
        MODE_RM_CB: begin
          i = 0;
          while (i < cnt) if (cb_q[i] == w.callback_id) drop_at(i); else i++;
        end
        MODE_QUERY: begin
          for (i = 0; i < cnt; i++) if (code_q[i] == w.msg_code) hit = 1'b1;
        end
        MODE_TICK: begin
          now_t = sat_add(now_t, TIME_BITS'(1));
          if (running) begin
            while (cnt > 0 && due_q[0] <= now_t) begin
              r = '0;
              r.dispatch_valid = 1'b1;
              r.out_code = code_q[0];
              r.out_callback = cb_q[0];
              released.push_back(r);
              drop_at(0);
            end
          end
        end
        MODE_STOP: running = 1'b0;
        default: ;
      endcase
      if (released.size() == 0) begin
        r = '0;
        r.status = st;
        r.found = hit;
        released.push_back(r);
      end
      released[released.size()-1].last = 1'b1;
      foreach (released[k]) begin
        released[k].pending_count = CNT_W'(cnt);
        expected_words.push_back(released[k]);
      end
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected result word %p", got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      cmp("status", e.status, got.status);
      cmp("found", e.found, got.found);
      cmp("pending_count", e.pending_count, got.pending_count);
      cmp("dispatch_valid", e.dispatch_valid, got.dispatch_valid);
      cmp("out_code", 64'(unsigned'(e.out_code)), 64'(unsigned'(got.out_code)));
      cmp("out_callback", e.out_callback, got.out_callback);
      cmp("last", e.last, got.last);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  dmtq_in_if  cmd_if();
  dmtq_out_if res_if();

  delayed_message_time_queue u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if.sink),
    .out_o (res_if.source)
  );

  msg_queue_scoreboard sb;
  bit calm;
  bit hold_req;
  int idle_cycles;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  task automatic send_word(mode_e m, logic signed [31:0] code, logic [7:0] cb,
                           logic [DELAY_W-1:0] dly);
    in_word_t w;
    int gap;
    w.mode = m;
    w.msg_code = code;
    w.callback_id = cb;
    w.delay_ms = dly;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data <= w;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_word(w);
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_code();
    return ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] pick_cb();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
  endfunction

  task automatic random_word(bit allow_stop);
    int p;
    logic [DELAY_W-1:0] d;
    p = $urandom_range(0, 99);
    d = ($urandom_range(0, 9) == 0) ? DELAY_W'($urandom) : DELAY_W'($urandom_range(0, 6));
    if (p < 35) send_word(MODE_DELAYED, pick_code(), pick_cb(), d);
    else if (p < 43) send_word(MODE_FRONT, pick_code(), pick_cb(), d);
    else if (p < 51) send_word(MODE_RM_CODE, pick_code(), pick_cb(), d);
    else if (p < 57) send_word(MODE_RM_CB, pick_code(), pick_cb(), d);
    else if (p < 65) send_word(MODE_QUERY, pick_code(), pick_cb(), d);
    else if (p < 97) send_word(MODE_TICK, pick_code(), pick_cb(), d);
    else if (p < 98 || !allow_stop) send_word(MODE_NONE, pick_code(), pick_cb(), d);
    else send_word(MODE_STOP, pick_code(), pick_cb(), d);
  endtask

  // result side: random stalls plus one long hold on request
  initial begin
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) sb.check_word(res_if.data);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
        res_if.ready <= 1'b1;
      end else if (stall > 0) begin
        stall--;
        res_if.ready <= (stall == 0);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    calm = 1'b0;
    hold_req = 1'b0;
    rst_ni = 1'b0;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every mode but stop, ties, full queue
    send_word(MODE_TICK, 0, 0, 0);
    send_word(MODE_FRONT, 32'sh7fffffff, 8'hff, '1);
    send_word(MODE_DELAYED, 32'sh80000000, 8'h00, '1);
    send_word(MODE_DELAYED, -1, 8'h01, 0);
    send_word(MODE_DELAYED, 5, 8'h02, 2);
    send_word(MODE_DELAYED, 6, 8'h03, 2);
    send_word(MODE_QUERY, 32'sh80000000, 0, 0);
    send_word(MODE_QUERY, 12345, 0, 0);
    send_word(MODE_NONE, 0, 0, 0);
    send_word(MODE_TICK, 0, 0, 0);
    send_word(MODE_TICK, 0, 0, 0);
    send_word(MODE_RM_CB, 0, 8'h00, 0);
    send_word(MODE_RM_CODE, 32'sh7fffffff, 0, 0);
    for (int i = 0; i < 17; i++) send_word(MODE_DELAYED, i, 8'(i), DELAY_W'(i % 3));
    send_word(MODE_FRONT, 99, 8'h55, 0);
    send_word(MODE_TICK, 0, 0, 0);
    send_word(MODE_TICK, 0, 0, 0);
    wait_drained();

    // long output stall while commands keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) random_word(1'b0);

    for (int i = 0; i < 330; i++) begin
      random_word(1'b0);
      if (i == 150) wait_drained();
    end

    // stopped queue, no idling to the end
    calm = 1'b1;
    send_word(MODE_STOP, 0, 0, 0);
    send_word(MODE_STOP, 0, 0, 0);
    for (int i = 0; i < 40; i++) random_word(1'b1);
    cmd_if.valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== delayed_message_time_queue.f =====
rtl/dmtq_pkg.sv
rtl/dmtq_if.sv
rtl/dmtq_store.sv
rtl/delayed_message_time_queue.sv
test/tb_delayed_message_time_queue.sv
